// File: rtl/core/mie_pkg.sv
// Shared types and constants for the modular inverse block.
// Used by the sequencer, the datapath and the top level. No dependencies.
`default_nettype none

package mie_pkg;

    localparam int          MIE_WORD_BITS     = 31;
    localparam logic [63:0] MIE_MODULUS_RESET = 64'd1000000007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_UPDATE,
        ST_FIX
    } mie_state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic update;
        logic out_write;
    } mie_ctrl_t;

    typedef struct packed {
        logic rc_zero;
    } mie_status_t;

endpackage

`default_nettype wire

// File: rtl/core/mie_seq.sv
// Sequencer for the modular inverse block: handshakes, state machine and
// division bit counter. Depends on mie_pkg.
`default_nettype none

module mie_seq #(
    parameter int WORD_BITS = mie_pkg::MIE_WORD_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire mie_pkg::mie_status_t status,
    output mie_pkg::mie_ctrl_t     ctrl
);
    import mie_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

    mie_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ctrl           = '0;
        // drop the held result once it is taken
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (status.rc_zero)
                begin
                    state_next = ST_FIX;
                end
                else
                begin
                    ctrl.div_init = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_UPDATE:
            begin
                ctrl.update = 1'b1;
                state_next  = ST_TEST;
            end
            ST_FIX:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    ctrl.out_write = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// File: rtl/core/mie_datapath.sv
// Datapath for the modular inverse block: remainder and coefficient
// registers around one shared restoring-division step. Depends on mie_pkg.
`default_nettype none

module mie_datapath #(
    parameter int WORD_BITS = mie_pkg::MIE_WORD_BITS
) (
    input  wire logic                 clk,
    input  wire mie_pkg::mie_ctrl_t   ctrl,
    output mie_pkg::mie_status_t      status,
    input  wire logic [WORD_BITS-1:0] value,
    input  wire logic [WORD_BITS-1:0] modulus,
    output logic [WORD_BITS-1:0]      inverse_value
);
    import mie_pkg::*;

    // coefficients stay within the larger operand; products within twice that
    localparam int CW = WORD_BITS + 3;

    logic [WORD_BITS-1:0]  rp_reg, rc_reg, dvd_reg, rem_reg;
    logic signed [CW-1:0]  cp_reg, cc_reg, prod_reg;
    logic [WORD_BITS-1:0]  inverse_reg;

    logic [WORD_BITS:0]    shifted;
    logic [WORD_BITS+1:0]  diff;
    logic                  qbit;
    logic [WORD_BITS-1:0]  rem_next;
    logic signed [CW-1:0]  prod_next;
    logic signed [CW-1:0]  fix_sum;

    // one division step: shift in a dividend bit, trial subtract,
    // and fold the quotient bit into quot * cc MSB first
    always_comb
    begin
        shifted   = {rem_reg, dvd_reg[WORD_BITS-1]};
        diff      = {1'b0, shifted} - {2'b00, rc_reg};
        qbit      = !diff[WORD_BITS+1];
        rem_next  = qbit ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
        prod_next = {prod_reg[CW-2:0], 1'b0} + (qbit ? cc_reg : {CW{1'b0}});
        fix_sum   = cp_reg[CW-1] ? (cp_reg + signed'({3'b000, modulus})) : cp_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rp_reg <= modulus;
            rc_reg <= value;
            cp_reg <= '0;
            cc_reg <= CW'(1);
        end
        if (ctrl.div_init)
        begin
            dvd_reg  <= rp_reg;
            rem_reg  <= '0;
            prod_reg <= '0;
        end
        if (ctrl.div_step)
        begin
            dvd_reg  <= {dvd_reg[WORD_BITS-2:0], 1'b0};
            rem_reg  <= rem_next;
            prod_reg <= prod_next;
        end
        if (ctrl.update)
        begin
            rp_reg <= rc_reg;
            rc_reg <= rem_reg;
            cp_reg <= cc_reg;
            cc_reg <= cp_reg - prod_reg;
        end
        if (ctrl.out_write)
        begin
            inverse_reg <= fix_sum[WORD_BITS-1:0];
        end
    end

    assign status.rc_zero = (rc_reg == '0);
    assign inverse_value  = inverse_reg;

endmodule

`default_nettype wire

// File: rtl/core/modular_inverse_ext_euclid.sv
// Modular inverse by the extended Euclidean algorithm, one item at a time.
// Each of the k Euclid iterations runs WORD_BITS division steps plus test and update
// (k <= ~46). Input stalls while an item is in work, so one item is taken at a time,
// and a stalled result holds the block before its final write.
// Reset: modulus returns to 1000000007, the sequencer goes idle, no output pending.
// Depends on mie_pkg, mie_seq and mie_datapath.
`default_nettype none

module modular_inverse_ext_euclid #(
    parameter int WORD_BITS = mie_pkg::MIE_WORD_BITS
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [WORD_BITS-1:0] value,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [WORD_BITS-1:0]      inverse_value,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [WORD_BITS-1:0] modulus
);
    import mie_pkg::*;

    logic [WORD_BITS-1:0] modulus_reg;
    mie_ctrl_t            ctrl;
    mie_status_t          status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MIE_MODULUS_RESET[WORD_BITS-1:0];
        end
        else if (cfg_valid && cfg_ready)
        begin
            modulus_reg <= modulus;
        end
    end

    assign cfg_ready = 1'b1;

    mie_seq #(
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .ctrl      (ctrl)
    );

    mie_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk           (clk),
        .ctrl          (ctrl),
        .status        (status),
        .value         (value),
        .modulus       (modulus_reg),
        .inverse_value (inverse_value)
    );

endmodule

`default_nettype wire

// File: rtl/core/mie_checker.sv
// Port-level checks for the modular inverse block, bound to the top level.
// Depends on mie_pkg and modular_inverse_ext_euclid.
`default_nettype none

module mie_checker #(
    parameter int WORD_BITS = mie_pkg::MIE_WORD_BITS
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 in_valid,
    input wire logic                 in_stall,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [WORD_BITS-1:0] inverse_value
);
    import mie_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(inverse_value))
        else $error("result changed or dropped while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted again right after an item");

    // no result appears the cycle after an accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared right after accept");

    // a fresh result comes only out of work in progress
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in work");

endmodule

bind modular_inverse_ext_euclid mie_checker #(
    .WORD_BITS (WORD_BITS)
) u_mie_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .inverse_value (inverse_value)
);

`default_nettype wire

// File: tb/modular_inverse_ext_euclid_tb.sv
// Self-checking testbench for the modular inverse block (extended Euclid).
// Drives items through the valid/stall ports, predicts each inverse in a scoreboard
// class and compares results in order. Depends on mie_pkg and modular_inverse_ext_euclid.
`timescale 1ns / 1ps

module modular_inverse_ext_euclid_tb;

    localparam int WORD_BITS    = mie_pkg::MIE_WORD_BITS;
    localparam int LIMIT_CYCLES = 3000000;

    typedef logic [WORD_BITS-1:0] word_t;

    class inverse_scoreboard;
        word_t modulus_copy;
        word_t queued_values[$];
        word_t queued_inverses[$];
        int    mismatch_count;

        function new();
            modulus_copy   = mie_pkg::MIE_MODULUS_RESET[WORD_BITS-1:0];
            mismatch_count = 0;
        endfunction

        // Remainder sequence from (modulus, x); coefficients in 64-bit two's complement.
        function word_t predict_inverse(word_t x);
            logic [63:0] rem_hi;
            logic [63:0] rem_lo;
            logic [63:0] rem_next;
            logic [63:0] coef_hi;
            logic [63:0] coef_lo;
            logic [63:0] coef_next;
            logic [63:0] quot;
            rem_hi  = {{(64-WORD_BITS){1'b0}}, modulus_copy};
            rem_lo  = {{(64-WORD_BITS){1'b0}}, x};
            coef_hi = 64'd0;
            coef_lo = 64'd1;
            while (rem_lo != 64'd0)
            begin
                quot      = rem_hi / rem_lo;
                rem_next  = rem_hi % rem_lo;
                coef_next = coef_hi - quot * coef_lo;
                rem_hi    = rem_lo;
                rem_lo    = rem_next;
                coef_hi   = coef_lo;
                coef_lo   = coef_next;
            end
            if (coef_hi[63])
                coef_hi = coef_hi + {{(64-WORD_BITS){1'b0}}, modulus_copy};
            return coef_hi[WORD_BITS-1:0];
        endfunction

        function void note_item(word_t x);
            queued_values.push_back(x);
            queued_inverses.push_back(predict_inverse(x));
        endfunction

        function int outstanding();
            return queued_inverses.size();
        endfunction

        task report_mismatch(string msg);
            $display("%0t: mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        task check_result(word_t got);
            word_t x;
            word_t want;
            if (queued_inverses.size() == 0)
            begin
                report_mismatch($sformatf("result %0d with no item pending", got));
            end
            else
            begin
                x    = queued_values.pop_front();
                want = queued_inverses.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("value %0d: inverse_value %0d, want %0d",
                                              x, got, want));
            end
        endtask
    endclass

    logic  clk = 1'b0;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    word_t item_value;
    logic  out_valid;
    logic  out_stall;
    word_t inverse_value;
    logic  cfg_valid;
    logic  cfg_ready;
    word_t cfg_modulus;

    inverse_scoreboard sb;
    int cycle_count = 0;
    bit send_steady = 1'b0;

    modular_inverse_ext_euclid #(
        .WORD_BITS(WORD_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (item_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .inverse_value(inverse_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .modulus      (cfg_modulus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic word_t pick_value(word_t m);
        word_t v;
        case ($urandom_range(0, 5))
            0:       v = word_t'($urandom_range(0, 64));
            1:       v = word_t'($urandom_range(0, int'(m) - 1));
            2:       v = m - word_t'($urandom_range(0, 3));
            3:       v = word_t'($urandom_range(1, 100000) * $urandom_range(2, 30));
            default: v = word_t'($urandom);
        endcase
        return v;
    endfunction

    // Call only right after an accepted item or while idle.
    task automatic send_value(word_t v);
        int gap;
        if ($urandom_range(0, 15) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        item_value <= v;
        do @(posedge clk); while (in_stall);
        sb.note_item(v);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_modulus(word_t m);
        drain_results();
        cfg_valid   <= 1'b1;
        cfg_modulus <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.modulus_copy = m;
    endtask

    task automatic send_random(int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            // hold the sender now and then until every inverse is back
            if ($urandom_range(0, 59) == 0)
                drain_results();
            send_value(pick_value(sb.modulus_copy));
        end
    endtask

    // Result side: at random, stall ahead of a result and keep stalling for a drawn number of cycles once it shows up.
    initial
    begin
        int hold;
        bit steady;
        steady = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                steady = !steady;
            hold = steady ? 0 : $urandom_range(0, 6);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                do @(posedge clk); while (!out_valid);
                repeat (hold - 1) @(posedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
            sb.check_result(inverse_value);
        end
    end

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        item_value  = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_modulus = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset modulus, a prime
        send_value(word_t'(0));
        send_value(word_t'(1));
        send_value(word_t'(2));
        send_value(word_t'(1000000006));
        send_value(word_t'(1000000007));
        send_value(word_t'(1000000008));
        send_value(word_t'(31'h7FFFFFFF));
        send_value(word_t'(31'h55555555));
        send_value(word_t'(31'h2AAAAAAA));
        send_value(word_t'(500000004));
        send_random(40);

        set_modulus(word_t'(2));
        send_value(word_t'(0));
        send_value(word_t'(1));
        send_value(word_t'(3));
        send_random(62);

        set_modulus(word_t'(2147483647));
        send_value(word_t'(2147483647));
        send_value(word_t'(2147483646));
        send_value(word_t'(1134903170));
        send_random(62);

        // consecutive Fibonacci numbers: longest remainder chain
        set_modulus(word_t'(1836311903));
        send_value(word_t'(1134903170));
        send_value(word_t'(1836311902));
        send_value(word_t'(701408733));
        send_random(62);

        // composite moduli: many values share a factor
        set_modulus(word_t'(1073741824));
        send_value(word_t'(6));
        send_value(word_t'(1073741823));
        send_value(word_t'(1073741824));
        send_value(word_t'(3));
        send_random(62);

        set_modulus(word_t'(360360));
        send_value(word_t'(360359));
        send_value(word_t'(720720));
        send_value(word_t'(1001));
        send_random(62);

        set_modulus(word_t'($urandom_range(2, 2147483647)));
        send_random(62);

        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
